// ===== sv/ps2mct_pkg.sv =====
// Shared types and constants for the mouse packet cursor tracker.
package ps2mct_pkg;

   // Widths of the item fields and configuration registers.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned POS_W    = 12;
   localparam int unsigned PULL_W   = 4;
   localparam int unsigned SUM_W    = POS_W + 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 32;

   // Header sync bit and button bits of the first packet byte.
   localparam int unsigned HDR_SYNC_BIT  = 3;
   localparam int unsigned HDR_LEFT_BIT  = 0;
   localparam int unsigned HDR_RIGHT_BIT = 1;

   // Reset values.
   localparam logic [POS_W-1:0]  CURSOR_RESET        = 12'd256;
   localparam logic [POS_W-1:0]  DISP_WIDTH_RESET    = 12'd640;
   localparam logic [POS_W-1:0]  DISP_HEIGHT_RESET   = 12'd480;
   localparam logic [PULL_W-1:0] CURSOR_WIDTH_RESET  = 4'd8;
   localparam logic [PULL_W-1:0] CURSOR_HEIGHT_RESET = 4'd8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_HEIGHT = 2'd3;

   // Current configuration, handed from the register file to the tracker.
   typedef struct packed {
      logic [POS_W-1:0]  disp_width;
      logic [POS_W-1:0]  disp_height;
      logic [PULL_W-1:0] cursor_width;
      logic [PULL_W-1:0] cursor_height;
   } cfg_type;

endpackage

// ===== sv/ps2mct_axis_clamp.sv =====
// Clamp of one cursor axis against the screen bound and the cursor pull-back.
module ps2mct_axis_clamp
   import ps2mct_pkg::*;
(
   input  logic signed [SUM_W-1:0] pos_sum,
   input  logic [POS_W-1:0]        bound,
   input  logic [PULL_W-1:0]       pull,
   output logic [POS_W-1:0]        pos_out
);

   logic signed [SUM_W-1:0] bound_s;
   logic [POS_W-1:0]        pull_ext;

   assign bound_s  = signed'({2'b00, bound});
   assign pull_ext = {{(POS_W-PULL_W){1'b0}}, pull};

   // Above the bound pulls back from it (saturating at zero); below one
   // pushes in from the left or top edge.
   always_comb begin
      if (pos_sum > bound_s) begin
         pos_out = (bound >= pull_ext) ? (bound - pull_ext) : '0;
      end else if (pos_sum < SUM_W'(1)) begin
         pos_out = pull_ext + POS_W'(1);
      end else begin
         pos_out = pos_sum[POS_W-1:0];
      end
   end

endmodule

// ===== sv/ps2mct_tracker.sv =====
// Packet byte sequencer, cursor state and result register.
module ps2mct_tracker
   import ps2mct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   input  logic [BYTE_W-1:0]     in_byte,
   output logic                  in_take,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [POS_W-1:0]      out_pos_x,
   output logic [POS_W-1:0]      out_pos_y,
   output logic                  out_pressed
);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_DX   = 2'd1,
      PH_DY   = 2'd2
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [BYTE_W-1:0]       header_ff, header_in;
   logic [BYTE_W-1:0]       dx_ff, dx_in;
   logic [POS_W-1:0]        cursor_x_ff, cursor_x_in;
   logic [POS_W-1:0]        cursor_y_ff, cursor_y_in;
   logic                    out_valid_ff, out_valid_in;
   logic [POS_W-1:0]        out_x_ff, out_x_in;
   logic [POS_W-1:0]        out_y_ff, out_y_in;
   logic                    out_pressed_ff, out_pressed_in;

   logic                    out_free;
   logic signed [SUM_W-1:0] sum_x;
   logic signed [SUM_W-1:0] sum_y;
   logic [POS_W-1:0]        clamp_x;
   logic [POS_W-1:0]        clamp_y;

   // The result register frees up when empty or being taken this cycle.
   assign out_free = !out_valid_ff || out_ready;
   assign in_take  = in_valid && out_free;

   // X adds the delta; device Y is inverted, so Y subtracts it.
   assign sum_x = signed'({2'b00, cursor_x_ff}) + SUM_W'(signed'(dx_ff));
   assign sum_y = signed'({2'b00, cursor_y_ff}) - SUM_W'(signed'(in_byte));

   ps2mct_axis_clamp u_clamp_x (
      .pos_sum (sum_x),
      .bound   (cfg.disp_width),
      .pull    (cfg.cursor_width),
      .pos_out (clamp_x)
   );

   ps2mct_axis_clamp u_clamp_y (
      .pos_sum (sum_y),
      .bound   (cfg.disp_height),
      .pull    (cfg.cursor_height),
      .pos_out (clamp_y)
   );

   // Next state for each byte taken; the third byte loads the result register.
   always_comb begin
      phase_in       = phase_ff;
      header_in      = header_ff;
      dx_in          = dx_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      out_valid_in   = out_valid_ff && !out_ready;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_pressed_in = out_pressed_ff;
      if (in_take) begin
         unique case (phase_ff)
            PH_DX: begin
               dx_in    = in_byte;
               phase_in = PH_DY;
            end
            PH_DY: begin
               phase_in       = PH_HUNT;
               cursor_x_in    = clamp_x;
               cursor_y_in    = clamp_y;
               out_valid_in   = 1'b1;
               out_x_in       = clamp_x;
               out_y_in       = clamp_y;
               out_pressed_in = header_ff[HDR_LEFT_BIT] | header_ff[HDR_RIGHT_BIT];
            end
            default: begin
               // Hunting: every byte is latched, only a sync bit starts a packet.
               header_in = in_byte;
               phase_in  = in_byte[HDR_SYNC_BIT] ? PH_DX : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         header_ff    <= '0;
         dx_ff        <= '0;
         cursor_x_ff  <= CURSOR_RESET;
         cursor_y_ff  <= CURSOR_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         header_ff    <= header_in;
         dx_ff        <= dx_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         out_valid_ff <= out_valid_in;
      end
      out_x_ff       <= out_x_in;
      out_y_ff       <= out_y_in;
      out_pressed_ff <= out_pressed_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_pos_x   = out_x_ff;
   assign out_pos_y   = out_y_ff;
   assign out_pressed = out_pressed_ff;

endmodule

// ===== sv/ps2_mouse_packet_cursor_tracker_unit.sv =====
// Mouse packet cursor tracker: input register, configuration registers and tracker.
//
// Takes one raw mouse byte per item and, on the third byte of each three-byte
// packet, returns the clamped cursor position and a button-pressed flag. A
// byte without bit 3 set is dropped while hunting for a header. The block
// accepts one byte every cycle; a byte passes an input register and then the
// add-and-clamp logic into the result register, and a result item is offered
// once its last byte is loaded there. Back-pressure on the result side stalls
// the input only once both the result register and the input register are
// full.
// Configuration registers should be written only while no packet is in flight.
module ps2_mouse_packet_cursor_tracker_unit
   import ps2mct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [11:0] pos_x, [23:12] pos_y,
                                              // [24] pressed, [31:25] zero
   // Configuration writes.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [POS_W-1:0]      csr_wdata
);

   cfg_type             cfg_ff, cfg_in;
   logic                in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]   in_byte_ff, in_byte_in;
   logic                in_take;
   logic [POS_W-1:0]    pos_x;
   logic [POS_W-1:0]    pos_y;
   logic                pressed;

   // Configuration register file.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DISP_WIDTH:    cfg_in.disp_width    = csr_wdata;
            CSR_DISP_HEIGHT:   cfg_in.disp_height   = csr_wdata;
            CSR_CURSOR_WIDTH:  cfg_in.cursor_width  = csr_wdata[PULL_W-1:0];
            CSR_CURSOR_HEIGHT: cfg_in.cursor_height = csr_wdata[PULL_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Input register: refilled whenever it is empty or drains this cycle.
   assign req_tready  = !in_valid_ff || in_take;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !in_take);
   assign in_byte_in  = (req_tvalid && req_tready) ? req_tdata[BYTE_W-1:0] : in_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disp_width    <= DISP_WIDTH_RESET;
         cfg_ff.disp_height   <= DISP_HEIGHT_RESET;
         cfg_ff.cursor_width  <= CURSOR_WIDTH_RESET;
         cfg_ff.cursor_height <= CURSOR_HEIGHT_RESET;
         in_valid_ff          <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   ps2mct_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (in_valid_ff),
      .in_byte     (in_byte_ff),
      .in_take     (in_take),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_pos_x   (pos_x),
      .out_pos_y   (pos_y),
      .out_pressed (pressed)
   );

   // Result packing, first field in the lowest bits.
   assign rsp_tdata = {{(RSP_DATA_W - 2*POS_W - 1){1'b0}}, pressed, pos_y, pos_x};

endmodule

// ===== sv/ps2mct_checker.sv =====
// Port-level assertions for the mouse packet cursor tracker, bound to the top level.
module ps2mct_checker
   import ps2mct_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Padding bits above the pressed flag stay zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:2*POS_W+1] == '0)
      else $error("result padding bits not zero");

   // No result can be shown directly after reset: a packet needs
   // three bytes plus the input and result registers.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("result item appeared too soon after reset");

   // An empty output side never blocks input.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(!rsp_tvalid) && !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty result side");

endmodule

bind ps2_mouse_packet_cursor_tracker_unit ps2mct_checker u_ps2mct_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the mouse packet cursor tracker unit.
module testbench
   import ps2mct_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned ITEMS_PER_RUN = 87;
   localparam int unsigned SETTLE_CYCLES = 6;

   // Where the tracker stands inside a three-byte packet.
   typedef enum logic [1:0] {
      HUNT_HEADER = 2'd0,
      WAIT_DX     = 2'd1,
      WAIT_DY     = 2'd2
   } packet_phase_type;

   // One cursor report as it leaves the block.
   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic             pressed;
   } cursor_report_type;

   // Tracks cursor state from accepted bytes and checks the reports against it.
   class cursor_scoreboard_type;
      logic [POS_W-1:0]  scr_w, scr_h;
      logic [PULL_W-1:0] pull_w, pull_h;
      packet_phase_type  phase;
      logic [BYTE_W-1:0] hdr, dx_byte;
      logic [POS_W-1:0]  cur_x, cur_y;
      cursor_report_type pending[$];
      int                errors;

      function new();
         scr_w   = DISP_WIDTH_RESET;
         scr_h   = DISP_HEIGHT_RESET;
         pull_w  = CURSOR_WIDTH_RESET;
         pull_h  = CURSOR_HEIGHT_RESET;
         phase   = HUNT_HEADER;
         hdr     = '0;
         dx_byte = '0;
         cur_x   = CURSOR_RESET;
         cur_y   = CURSOR_RESET;
         errors  = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [POS_W-1:0] val);
         unique case (idx)
            CSR_DISP_WIDTH:    scr_w  = val;
            CSR_DISP_HEIGHT:   scr_h  = val;
            CSR_CURSOR_WIDTH:  pull_w = val[PULL_W-1:0];
            CSR_CURSOR_HEIGHT: pull_h = val[PULL_W-1:0];
            default: ;
         endcase
      endfunction

      // Out-of-range positions are pulled back inside by the cursor size.
      function logic [POS_W-1:0] fit_axis(int v, int size, int pull);
         if (v > size) return (size >= pull) ? POS_W'(size - pull) : '0;
         if (v < 1) return POS_W'(1 + pull);
         return POS_W'(v);
      endfunction

      function void note_byte(logic [BYTE_W-1:0] b);
         cursor_report_type rep;
         int nx, ny;
         unique case (phase)
            WAIT_DX: begin
               dx_byte = b;
               phase = WAIT_DY;
            end
            WAIT_DY: begin
               nx = int'(cur_x) + int'($signed(dx_byte));
               ny = int'(cur_y) - int'($signed(b));
               cur_x = fit_axis(nx, int'(scr_w), int'(pull_w));
               cur_y = fit_axis(ny, int'(scr_h), int'(pull_h));
               rep.pos_x = cur_x;
               rep.pos_y = cur_y;
               rep.pressed = hdr[HDR_LEFT_BIT] | hdr[HDR_RIGHT_BIT];
               pending.push_back(rep);
               phase = HUNT_HEADER;
            end
            default: begin
               // Any byte is latched, but only one with the sync bit starts a packet.
               hdr = b;
               phase = b[HDR_SYNC_BIT] ? WAIT_DX : HUNT_HEADER;
            end
         endcase
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] d);
         cursor_report_type want;
         cursor_report_type got;
         got.pos_x = d[POS_W-1:0];
         got.pos_y = d[2*POS_W-1:POS_W];
         got.pressed = d[2*POS_W];
         if (pending.size() == 0) begin
            $display("%0t: unexpected report pos_x=%0d pos_y=%0d pressed=%0d",
                     $time, got.pos_x, got.pos_y, got.pressed);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.pos_x !== want.pos_x) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
            errors++;
         end
         if (got.pos_y !== want.pos_y) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
            errors++;
         end
         if (got.pressed !== want.pressed) begin
            $display("%0t: pressed expected %0d actual %0d",
                     $time, want.pressed, got.pressed);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [11:0] pos_x, [23:12] pos_y, [24] pressed
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [POS_W-1:0]      csr_wdata = '0;

   cursor_scoreboard_type tracker_sb = new();
   bit                    calm = 1'b0;
   int unsigned           cycle_count = 0;

   ps2_mouse_packet_cursor_tracker_unit dut (.*);

   always #1 clock = ~clock;

   // Watch both channels and feed the scoreboard.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) tracker_sb.note_byte(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) tracker_sb.check_result(rsp_tdata);
   end

   // Result side: random stalls before each item, none during calm stretches.
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** ps2_mouse_packet_cursor_tracker_unit: FAILED **");
      $finish;
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_packet(input logic [BYTE_W-1:0] hdr, dx, dy);
      send_byte(hdr);
      send_byte(dx);
      send_byte(dy);
   endtask

   // Stop sending and wait for every pending report, then a further settle wait.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker_sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_setting(input logic [POS_W-1:0] w, h, cw, ch);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [POS_W-1:0]     vals [4];
      idx  = '{CSR_DISP_WIDTH, CSR_DISP_HEIGHT, CSR_CURSOR_WIDTH, CSR_CURSOR_HEIGHT};
      vals = '{w, h, cw, ch};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         tracker_sb.set_reg(idx[i], vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Deltas lean toward full-scale moves so the clamps get exercised.
   function automatic logic [BYTE_W-1:0] pick_delta(bit drift_up);
      case ($urandom_range(0, 3))
         0: return drift_up ? 8'h7F : 8'h80;
         1: return BYTE_W'($urandom_range(0, 8) - 4);
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   // Mostly well-formed packets with random content, some stray non-header bytes.
   task automatic random_packets();
      int  sent;
      bit  paused;
      bit  up_x, up_y;
      sent = 0;
      paused = 1'b0;
      up_x = 1'($urandom_range(0, 1));
      up_y = 1'($urandom_range(0, 1));
      while (sent < ITEMS_PER_RUN) begin
         if ($urandom_range(0, 9) == 0) begin
            send_byte(BYTE_W'($urandom) & ~8'h08);
         end else begin
            send_packet(BYTE_W'($urandom) | 8'h08, pick_delta(up_x), pick_delta(up_y));
            sent += 3;
         end
         if (!paused && sent >= ITEMS_PER_RUN / 2) begin
            drain_reports();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      logic [POS_W-1:0] w, h;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items under the reset configuration: stray bytes, each
      // button combination and the extreme deltas.
      send_byte(8'h00);
      send_byte(8'hF7);
      send_packet(8'h08, 8'h7F, 8'h80);
      send_packet(8'h09, 8'h80, 8'h7F);
      send_packet(8'h0A, 8'hFF, 8'h01);
      send_packet(8'hFF, 8'h00, 8'h00);
      send_packet(8'h0B, 8'h01, 8'hFF);
      drain_reports();

      // A small screen with the largest cursor: clamp above, then below.
      load_setting(12'd16, 12'd16, 12'd15, 12'd15);
      send_packet(8'h0C, 8'h7F, 8'h00);
      send_packet(8'h0D, 8'h80, 8'h7F);

      // Random runs across a range of settings, some without any idling.
      for (int run = 0; run < 8; run++) begin
         drain_reports();
         calm = (run % 3 == 2);
         case (run)
            0: ;
            1: load_setting(12'd4095, 12'd4095, 12'd0, 12'd0);
            2: load_setting(12'd5, 12'd3, 12'd15, 12'd15);  // screen below cursor size
            3: load_setting(12'd0, 12'd4095, 12'h5A7, 12'hFF0);
            4: load_setting(DISP_WIDTH_RESET, DISP_HEIGHT_RESET,
                            12'(CURSOR_WIDTH_RESET), 12'(CURSOR_HEIGHT_RESET));
            default: begin
               w = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 15))
                                               : POS_W'($urandom_range(16, 4095));
               h = POS_W'($urandom_range(16, 4095));
               load_setting(w, h, POS_W'($urandom_range(0, 4095)),
                            POS_W'($urandom_range(0, 4095)));
            end
         endcase
         random_packets();
      end

      calm = 1'b0;
      drain_reports();
      if (tracker_sb.errors == 0)
         $display("** ps2_mouse_packet_cursor_tracker_unit: PASSED **");
      else
         $display("** ps2_mouse_packet_cursor_tracker_unit: FAILED **");
      $finish;
   end

endmodule
